### hdl/trd_pkg.sv
`timescale 1ns / 1ps

package trd_pkg;

  // Screen geometry and store layout.
  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;
  localparam int PIXELS   = SCREEN_W * SCREEN_H;
  localparam int ADDR_W   = $clog2(PIXELS);
  localparam int POS_W    = 11;

  // Values written by a clear.
  localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic [7:0]         BLACK   = 8'd0;

  // Command codes; the last code is not assigned and has no effect.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;

  // One store entry: depth and color side by side.
  typedef struct packed {
    logic signed [31:0] depth;
    logic [7:0]         color;
  } pixel_t;

  // Access request from the sequencer to the pixel store.
  typedef struct packed {
    logic   we;
    addr_t  waddr;
    pixel_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_EDGE,
    ST_MUL,
    ST_SUM,
    ST_DIV_START,
    ST_DIV,
    ST_TEST,
    ST_NEXT,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

endpackage

### hdl/trd_item_if.sv
`timescale 1ns / 1ps

interface trd_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [11:0] ax;
  logic signed [11:0] ay;
  logic signed [31:0] az;
  logic signed [11:0] bx;
  logic signed [11:0] by;
  logic signed [31:0] bz;
  logic signed [11:0] cx;
  logic signed [11:0] cy;
  logic signed [31:0] cz;
  logic [7:0]         fill_color;

  modport source (output valid, command, ax, ay, az, bx, by, bz, cx, cy, cz, fill_color,
                  input ready);
  modport sink (input valid, command, ax, ay, az, bx, by, bz, cx, cy, cz, fill_color,
                output ready);
endinterface

### hdl/trd_result_if.sv
`timescale 1ns / 1ps

interface trd_result_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_color;
  logic signed [31:0] read_depth;
  logic [18:0]        pixels_written;

  modport source (output valid, read_color, read_depth, pixels_written, input ready);
  modport sink (input valid, read_color, read_depth, pixels_written, output ready);
endinterface

### hdl/triangle_raster_depth_test.sv
`timescale 1ns / 1ps

// Triangle rasteriser with a depth buffer over a 640 x 480 pixel store held in one
// synchronous memory of depth and color. Every item gives exactly one result item.
// After reset the block sweeps the store to maximum depth and black, one pixel a
// cycle, before it takes the first item. A clear command repeats that sweep. A draw
// visits each pixel of the clipped bounding box; the depth of each covered pixel is
// worked out by the 64-step serial divider. A degenerate or off-screen triangle ends
// after setup.
module triangle_raster_depth_test (
  input logic         clk,
  input logic         rst,
  trd_item_if.sink    item,
  trd_result_if.source result
);

  trd_pkg::state_t state, state_next;

  // Latched item.
  logic [1:0]         cmd;
  logic signed [11:0] ax, ay, bx, by, cx, cy;
  logic signed [31:0] az, bz, cz;
  logic [7:0]         col;
  logic               clr_cmd;

  // Triangle setup.
  logic signed [12:0] ea, eb, fa, fb;
  logic signed [28:0] d;
  trd_pkg::pos_t      x1, y0, y1, px, py;

  // Per-pixel datapath.
  logic signed [28:0] wa, wb, wc;
  logic               covered;
  logic signed [60:0] pa, pb, pc;
  logic signed [63:0] num;
  logic [18:0]        count;
  trd_pkg::addr_t     clr_addr;

  // Result being built.
  logic [7:0]         res_color;
  logic signed [31:0] res_depth;

  trd_pkg::mem_req_t  mem_req;
  trd_pkg::pixel_t    mem_rdata;
  logic               div_start, div_done;
  logic signed [31:0] div_quo;

  // Setup arithmetic.
  logic signed [12:0] lo_x, hi_x, lo_y, hi_y, cx0, cx1, cy0, cy1;
  logic signed [26:0] d_ab, d_cd;
  logic               box_empty;
  logic signed [28:0] d_calc;

  // Edge function arithmetic.
  logic signed [12:0] dx, dy;
  logic signed [26:0] wa_calc, wb_calc;
  logic signed [28:0] wc_calc;
  logic               inside_calc;

  logic               last_pixel, in_screen;
  trd_pkg::addr_t     pix_addr;

  trd_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  trd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (d),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Bounding box clipped to the screen, and twice the signed triangle area.
  always_comb begin
    lo_x = 13'(ax);
    if (13'(bx) < lo_x) lo_x = 13'(bx);
    if (13'(cx) < lo_x) lo_x = 13'(cx);
    hi_x = 13'(ax);
    if (13'(bx) > hi_x) hi_x = 13'(bx);
    if (13'(cx) > hi_x) hi_x = 13'(cx);
    lo_y = 13'(ay);
    if (13'(by) < lo_y) lo_y = 13'(by);
    if (13'(cy) < lo_y) lo_y = 13'(cy);
    hi_y = 13'(ay);
    if (13'(by) > hi_y) hi_y = 13'(by);
    if (13'(cy) > hi_y) hi_y = 13'(cy);
    cx0 = (lo_x < 13'sd0) ? 13'sd0 : lo_x;
    cy0 = (lo_y < 13'sd0) ? 13'sd0 : lo_y;
    cx1 = (hi_x > 13'(trd_pkg::SCREEN_W - 1)) ? 13'(trd_pkg::SCREEN_W - 1) : hi_x;
    cy1 = (hi_y > 13'(trd_pkg::SCREEN_H - 1)) ? 13'(trd_pkg::SCREEN_H - 1) : hi_y;
    box_empty = (cx0 > cx1) || (cy0 > cy1);
    d_ab = 27'(13'(by) - 13'(cy)) * 27'(13'(ax) - 13'(cx));
    d_cd = 27'(13'(cx) - 13'(bx)) * 27'(13'(ay) - 13'(cy));
    d_calc = 29'(d_ab) + 29'(d_cd);
  end

  // Edge functions for the current pixel.
  always_comb begin
    dx = 13'($signed({2'b00, px})) - 13'(cx);
    dy = 13'($signed({2'b00, py})) - 13'(cy);
    wa_calc = 27'(ea) * 27'(dx) + 27'(eb) * 27'(dy);
    wb_calc = 27'(fa) * 27'(dx) + 27'(fb) * 27'(dy);
    wc_calc = d - 29'(wa_calc) - 29'(wb_calc);
    if (!d[28]) begin
      inside_calc = !wa_calc[26] && !wb_calc[26] && !wc_calc[28];
    end else begin
      inside_calc = (wa_calc[26] || wa_calc == 27'sd0) &&
                    (wb_calc[26] || wb_calc == 27'sd0) &&
                    (wc_calc[28] || wc_calc == 29'sd0);
    end
  end

  assign last_pixel = (py == y1) && (px == x1);
  assign in_screen  = (ax >= 12'sd0) && (ax < 12'(trd_pkg::SCREEN_W)) &&
                      (ay >= 12'sd0) && (ay < 12'(trd_pkg::SCREEN_H));

  // Row-major pixel address for draw and read.
  always_comb begin
    if (state == trd_pkg::ST_READ) begin
      pix_addr = trd_pkg::ADDR_W'(ay[10:0]) * trd_pkg::ADDR_W'(trd_pkg::SCREEN_W)
               + trd_pkg::ADDR_W'(ax[10:0]);
    end else begin
      pix_addr = trd_pkg::ADDR_W'(py) * trd_pkg::ADDR_W'(trd_pkg::SCREEN_W)
               + trd_pkg::ADDR_W'(px);
    end
  end

  // Store accesses.
  always_comb begin
    mem_req = '0;
    mem_req.raddr = pix_addr;
    mem_req.re    = (state == trd_pkg::ST_DIV_START) ||
                    (state == trd_pkg::ST_READ && in_screen);
    if (state == trd_pkg::ST_CLEAR) begin
      mem_req.we          = 1'b1;
      mem_req.waddr       = clr_addr;
      mem_req.wdata.depth = trd_pkg::INT_MAX;
      mem_req.wdata.color = trd_pkg::BLACK;
    end else if (state == trd_pkg::ST_TEST && div_quo < mem_rdata.depth) begin
      mem_req.we          = 1'b1;
      mem_req.waddr       = pix_addr;
      mem_req.wdata.depth = div_quo;
      mem_req.wdata.color = col;
    end
  end

  assign div_start  = (state == trd_pkg::ST_DIV_START);
  assign item.ready = (state == trd_pkg::ST_IDLE);

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      trd_pkg::ST_CLEAR: begin
        if (clr_addr == trd_pkg::ADDR_W'(trd_pkg::PIXELS - 1)) begin
          state_next = clr_cmd ? trd_pkg::ST_DONE : trd_pkg::ST_IDLE;
        end
      end
      trd_pkg::ST_IDLE: begin
        if (item.valid) begin
          unique case (item.command)
            trd_pkg::CMD_CLEAR: state_next = trd_pkg::ST_CLEAR;
            trd_pkg::CMD_DRAW:  state_next = trd_pkg::ST_SETUP;
            trd_pkg::CMD_READ:  state_next = trd_pkg::ST_READ;
            default:            state_next = trd_pkg::ST_DONE;
          endcase
        end
      end
      trd_pkg::ST_SETUP: begin
        state_next = (d_calc == 29'sd0 || box_empty) ? trd_pkg::ST_DONE : trd_pkg::ST_EDGE;
      end
      trd_pkg::ST_EDGE:      state_next = trd_pkg::ST_MUL;
      trd_pkg::ST_MUL:       state_next = covered ? trd_pkg::ST_SUM : trd_pkg::ST_NEXT;
      trd_pkg::ST_SUM:       state_next = trd_pkg::ST_DIV_START;
      trd_pkg::ST_DIV_START: state_next = trd_pkg::ST_DIV;
      trd_pkg::ST_DIV:       state_next = div_done ? trd_pkg::ST_TEST : trd_pkg::ST_DIV;
      trd_pkg::ST_TEST:      state_next = trd_pkg::ST_NEXT;
      trd_pkg::ST_NEXT:      state_next = last_pixel ? trd_pkg::ST_DONE : trd_pkg::ST_EDGE;
      trd_pkg::ST_READ:      state_next = in_screen ? trd_pkg::ST_READ_WAIT : trd_pkg::ST_DONE;
      trd_pkg::ST_READ_WAIT: state_next = trd_pkg::ST_DONE;
      trd_pkg::ST_DONE: begin
        if (!result.valid || result.ready) state_next = trd_pkg::ST_IDLE;
      end
      default: state_next = trd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      clr_cmd      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (state == trd_pkg::ST_DONE && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (state == trd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + trd_pkg::ADDR_W'(1);
      end
      if (state == trd_pkg::ST_IDLE && item.valid) begin
        clr_cmd  <= (item.command == trd_pkg::CMD_CLEAR);
        clr_addr <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      trd_pkg::ST_IDLE: begin
        cmd       <= item.command;
        ax        <= item.ax;
        ay        <= item.ay;
        az        <= item.az;
        bx        <= item.bx;
        by        <= item.by;
        bz        <= item.bz;
        cx        <= item.cx;
        cy        <= item.cy;
        cz        <= item.cz;
        col       <= item.fill_color;
        count     <= '0;
        res_color <= '0;
        res_depth <= '0;
      end
      trd_pkg::ST_SETUP: begin
        d  <= d_calc;
        ea <= 13'(by) - 13'(cy);
        eb <= 13'(cx) - 13'(bx);
        fa <= 13'(cy) - 13'(ay);
        fb <= 13'(ax) - 13'(cx);
        x1 <= cx1[10:0];
        y0 <= cy0[10:0];
        y1 <= cy1[10:0];
        px <= cx0[10:0];
        py <= cy0[10:0];
      end
      trd_pkg::ST_EDGE: begin
        wa      <= 29'(wa_calc);
        wb      <= 29'(wb_calc);
        wc      <= wc_calc;
        covered <= inside_calc;
      end
      trd_pkg::ST_MUL: begin
        pa <= 61'(wa) * 61'(az);
        pb <= 61'(wb) * 61'(bz);
        pc <= 61'(wc) * 61'(cz);
      end
      trd_pkg::ST_SUM: begin
        num <= 64'(pa) + 64'(pb) + 64'(pc);
      end
      trd_pkg::ST_TEST: begin
        if (div_quo < mem_rdata.depth) begin
          count <= count + 19'd1;
        end
      end
      trd_pkg::ST_NEXT: begin
        // Columns outer, rows inner.
        if (py == y1) begin
          py <= y0;
          px <= px + trd_pkg::POS_W'(1);
        end else begin
          py <= py + trd_pkg::POS_W'(1);
        end
      end
      trd_pkg::ST_READ_WAIT: begin
        res_color <= mem_rdata.color;
        res_depth <= mem_rdata.depth;
      end
      trd_pkg::ST_DONE: begin
        if (!result.valid || result.ready) begin
          result.read_color     <= res_color;
          result.read_depth     <= res_depth;
          result.pixels_written <= (cmd == trd_pkg::CMD_DRAW) ? count : 19'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // No item is taken while the store is being swept.
  assert property (@(posedge clk) disable iff (rst)
    (state == trd_pkg::ST_CLEAR) |-> !item.ready)
    else $error("item taken during store sweep");

  // The store is written only by the sweep or by a passing depth test.
  assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == trd_pkg::ST_CLEAR || state == trd_pkg::ST_TEST))
    else $error("unexpected store write");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == trd_pkg::ST_DIV))
    else $error("divider result arrived outside its wait state");

  // A new result is only loaded once the previous one has gone.
  assert property (@(posedge clk) disable iff (rst)
    (state == trd_pkg::ST_DONE && result.valid && !result.ready) |=>
      (state == trd_pkg::ST_DONE))
    else $error("result overwritten before it was taken");

endmodule

### hdl/trd_mem.sv
`timescale 1ns / 1ps

module trd_mem (
  input  logic              clk,
  input  trd_pkg::mem_req_t req,
  output trd_pkg::pixel_t   rdata
);

  trd_pkg::pixel_t store [trd_pkg::PIXELS];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= store[req.raddr];
    end
  end

endmodule

### hdl/trd_div.sv
`timescale 1ns / 1ps

module trd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [28:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic [63:0] dvd;
  logic [28:0] dvs;
  logic [28:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [29:0] trial;

  assign trial = {rem, dvd[63]};

  // Restoring division of magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= num[63] ? 64'(-num) : 64'(num);
        dvs  <= den[28] ? 29'(-den) : 29'(den);
        neg  <= num[63] ^ den[28];
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= 29'(trial - {1'b0, dvs});
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= trial[28:0];
          dvd <= {dvd[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Truncation toward zero: fix the sign of the magnitude quotient.
  assign quo = neg ? -$signed(dvd[31:0]) : $signed(dvd[31:0]);

endmodule

### tb/tb_triangle_raster_depth_test.sv
`timescale 1ns / 1ps

module tb_triangle_raster_depth_test;
  import trd_pkg::*;

  // One command item as the sender drives it.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [11:0] ax;
    logic signed [11:0] ay;
    logic signed [31:0] az;
    logic signed [11:0] bx;
    logic signed [11:0] by;
    logic signed [31:0] bz;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic signed [31:0] cz;
    logic [7:0]         fill_color;
  } raster_cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]         color;
    logic signed [31:0] depth;
    logic [18:0]        written;
  } raster_res_t;

  // A row of the directed table; known rows carry their result typed in.
  typedef struct packed {
    raster_cmd_t cmd;
    logic        known;
    raster_res_t res;
  } stim_row_t;

  logic clk;
  logic rst;

  trd_item_if   item_ch();
  trd_result_if res_ch();

  triangle_raster_depth_test dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (res_ch.source)
  );

  // Shadow copy of the pixel store.
  int          shadow_depth [PIXELS];
  byte unsigned shadow_color [PIXELS];

  raster_res_t expected_q [$];
  stim_row_t   rows [$];
  int          send_idle;
  int          recv_idle;
  int          mismatches;
  int          n_draw;
  int          n_read;
  int          n_clear;
  int          n_other;
  longint      n_pixels;

  // Clock with an 8 ns period.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the result of one command and updates the shadow store.
  function automatic raster_res_t raster_predict(raster_cmd_t c);
    raster_res_t r;
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint d, wa, wb, wc, z, x0, x1, y0, y1;
    longint unsigned n;
    bit in_tri;
    int idx;
    r = '0;
    n = 0;
    ax = c.ax; ay = c.ay; az = c.az;
    bx = c.bx; by = c.by; bz = c.bz;
    cx = c.cx; cy = c.cy; cz = c.cz;
    case (c.command)
      CMD_CLEAR: begin
        for (int i = 0; i < PIXELS; i++) begin
          shadow_depth[i] = INT_MAX;
          shadow_color[i] = BLACK;
        end
      end
      CMD_DRAW: begin
        d = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
        if (d != 0) begin
          x0 = ax < bx ? ax : bx; x0 = x0 < cx ? x0 : cx;
          x1 = ax > bx ? ax : bx; x1 = x1 > cx ? x1 : cx;
          y0 = ay < by ? ay : by; y0 = y0 < cy ? y0 : cy;
          y1 = ay > by ? ay : by; y1 = y1 > cy ? y1 : cy;
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > SCREEN_W - 1) x1 = SCREEN_W - 1;
          if (y1 > SCREEN_H - 1) y1 = SCREEN_H - 1;
          for (longint x = x0; x <= x1; x++) begin
            for (longint y = y0; y <= y1; y++) begin
              wa = (by - cy) * (x - cx) + (cx - bx) * (y - cy);
              wb = (cy - ay) * (x - cx) + (ax - cx) * (y - cy);
              wc = d - wa - wb;
              in_tri = (d > 0) ? (wa >= 0 && wb >= 0 && wc >= 0)
                               : (wa <= 0 && wb <= 0 && wc <= 0);
              if (in_tri) begin
                z = (wa * az + wb * bz + wc * cz) / d;
                idx = int'(y * SCREEN_W + x);
                if (z < longint'(shadow_depth[idx])) begin
                  shadow_depth[idx] = int'(z);
                  shadow_color[idx] = c.fill_color;
                  n++;
                end
              end
            end
          end
        end
        r.written = n[18:0];
      end
      CMD_READ: begin
        if (ax >= 0 && ax < SCREEN_W && ay >= 0 && ay < SCREEN_H) begin
          idx = int'(ay * SCREEN_W + ax);
          r.color = shadow_color[idx];
          r.depth = shadow_depth[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic raster_cmd_t mk(logic [1:0] op, int ax, int ay, int az,
                                     int bx, int by, int bz, int cx, int cy,
                                     int cz, int col);
    raster_cmd_t c;
    c.command = op;
    c.ax = 12'(ax); c.ay = 12'(ay); c.az = az;
    c.bx = 12'(bx); c.by = 12'(by); c.bz = bz;
    c.cx = 12'(cx); c.cy = 12'(cy); c.cz = cz;
    c.fill_color = 8'(col);
    return c;
  endfunction

  // Random depth: full range, small values, the extremes or moderate positive values.
  function automatic int rand_depth();
    case ($urandom_range(3))
      0: return int'($urandom);
      1: return int'($urandom_range(2000)) - 1000;
      2: return $urandom_range(1) ? INT_MAX : 32'sh8000_0000;
      default: return int'($urandom_range(100000));
    endcase
  endfunction

  // Random command: mostly small triangles and reads near them, plus noise.
  function automatic raster_cmd_t rand_cmd();
    raster_cmd_t c;
    int pick, bx0, by0, dx, dy, side;
    c = mk(CMD_DRAW, 0, 0, rand_depth(), 0, 0, rand_depth(), 0, 0, rand_depth(),
           $urandom_range(255));
    pick = $urandom_range(99);
    if ($urandom_range(4) == 0) begin
      bx0 = int'($urandom_range(SCREEN_W + 5)) - 3;
      by0 = int'($urandom_range(SCREEN_H + 5)) - 3;
    end else begin
      bx0 = $urandom_range(40);
      by0 = $urandom_range(30);
    end
    if (pick < 47) begin
      // Small triangle of either winding.
      c.ax = 12'(bx0 + int'($urandom_range(8)) - 4);
      c.ay = 12'(by0 + int'($urandom_range(8)) - 4);
      c.bx = 12'(bx0 + int'($urandom_range(8)) - 4);
      c.by = 12'(by0 + int'($urandom_range(8)) - 4);
      c.cx = 12'(bx0 + int'($urandom_range(8)) - 4);
      c.cy = 12'(by0 + int'($urandom_range(8)) - 4);
    end else if (pick < 55) begin
      // Collinear points.
      dx = int'($urandom_range(6)) - 3;
      dy = int'($urandom_range(6)) - 3;
      c.ax = 12'(bx0); c.ay = 12'(by0);
      c.bx = 12'(bx0 + dx); c.by = 12'(by0 + dy);
      c.cx = 12'(bx0 + 2 * dx); c.cy = 12'(by0 + 2 * dy);
    end else if (pick < 65) begin
      // Far triangle wholly off one side of the screen.
      c.ax = 12'($urandom); c.ay = 12'($urandom); c.bx = 12'($urandom);
      c.by = 12'($urandom); c.cx = 12'($urandom); c.cy = 12'($urandom);
      side = $urandom_range(3);
      if (side == 0) begin
        c.ax = 12'(-1 - int'($urandom_range(2047)));
        c.bx = 12'(-1 - int'($urandom_range(2047)));
        c.cx = 12'(-1 - int'($urandom_range(2047)));
      end else if (side == 1) begin
        c.ax = 12'(SCREEN_W + int'($urandom_range(2047 - SCREEN_W)));
        c.bx = 12'(SCREEN_W + int'($urandom_range(2047 - SCREEN_W)));
        c.cx = 12'(SCREEN_W + int'($urandom_range(2047 - SCREEN_W)));
      end else if (side == 2) begin
        c.ay = 12'(-1 - int'($urandom_range(2047)));
        c.by = 12'(-1 - int'($urandom_range(2047)));
        c.cy = 12'(-1 - int'($urandom_range(2047)));
      end else begin
        c.ay = 12'(SCREEN_H + int'($urandom_range(2047 - SCREEN_H)));
        c.by = 12'(SCREEN_H + int'($urandom_range(2047 - SCREEN_H)));
        c.cy = 12'(SCREEN_H + int'($urandom_range(2047 - SCREEN_H)));
      end
    end else if (pick < 88) begin
      c.command = CMD_READ;
      c.ax = 12'(bx0 + int'($urandom_range(8)) - 4);
      c.ay = 12'(by0 + int'($urandom_range(8)) - 4);
    end else if (pick < 95) begin
      c.command = CMD_READ;
      c.ax = 12'($urandom); c.ay = 12'($urandom);
      c.bx = 12'($urandom); c.by = 12'($urandom);
      c.cx = 12'($urandom); c.cy = 12'($urandom);
    end else begin
      c.command = CMD_UNUSED;
      c.ax = 12'($urandom); c.ay = 12'($urandom);
    end
    return c;
  endfunction

  // Drives one item, with a random gap first, and returns at its acceptance.
  task automatic send_cmd(raster_cmd_t c);
    int gap;
    bit acc;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.command    <= c.command;
    item_ch.ax         <= c.ax;
    item_ch.ay         <= c.ay;
    item_ch.az         <= c.az;
    item_ch.bx         <= c.bx;
    item_ch.by         <= c.by;
    item_ch.bz         <= c.bz;
    item_ch.cx         <= c.cx;
    item_ch.cy         <= c.cy;
    item_ch.cz         <= c.cz;
    item_ch.fill_color <= c.fill_color;
    do begin
      @(negedge clk);
      acc = item_ch.ready;
      @(posedge clk);
    end while (!acc);
    case (c.command)
      CMD_CLEAR: n_clear++;
      CMD_DRAW:  n_draw++;
      CMD_READ:  n_read++;
      default:   n_other++;
    endcase
  endtask

  // Pushes the expectation of an accepted item.
  task automatic log_expect(raster_cmd_t c, logic known, raster_res_t typed);
    raster_res_t p;
    p = raster_predict(c);
    n_pixels += p.written;
    expected_q.push_back(known ? typed : p);
  endtask

  task automatic drain();
    while (expected_q.size() > 0) @(posedge clk);
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result check; ready and valid are stable at the falling edge, so the
  // handshake seen here is the one taken at the next rising edge.
  always @(negedge clk) begin
    raster_res_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected: color %0d depth %0d written %0d",
                 $time, res_ch.read_color, res_ch.read_depth, res_ch.pixels_written);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res_ch.read_color !== exp_r.color) begin
          $display("%0t: read_color expected %0d actual %0d", $time, exp_r.color,
                   res_ch.read_color);
          mismatches++;
        end
        if (res_ch.read_depth !== exp_r.depth) begin
          $display("%0t: read_depth expected %0d actual %0d", $time, exp_r.depth,
                   res_ch.read_depth);
          mismatches++;
        end
        if (res_ch.pixels_written !== exp_r.written) begin
          $display("%0t: pixels_written expected %0d actual %0d", $time, exp_r.written,
                   res_ch.pixels_written);
          mismatches++;
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #(80_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence.
  initial begin
    raster_res_t fresh, none;
    fresh = '{color: BLACK, depth: INT_MAX, written: 19'd0};
    none  = '0;
    mismatches = 0;
    n_draw = 0; n_read = 0; n_clear = 0; n_other = 0; n_pixels = 0;
    send_idle = 37;
    recv_idle = 68;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    {item_ch.command, item_ch.ax, item_ch.ay, item_ch.az, item_ch.bx, item_ch.by,
     item_ch.bz, item_ch.cx, item_ch.cy, item_ch.cz, item_ch.fill_color} = '0;
    for (int i = 0; i < PIXELS; i++) begin
      shadow_depth[i] = INT_MAX;
      shadow_color[i] = BLACK;
    end

    // Directed table.
    rows.push_back('{mk(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fresh});
    rows.push_back('{mk(CMD_READ, 639, 479, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fresh});
    rows.push_back('{mk(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{mk(CMD_READ, 640, 479, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{mk(CMD_READ, -2048, 2047, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{mk(CMD_UNUSED, 5, 5, -1, 2047, -2048, -1, 0, 0, 0, 255), 1'b1, none});
    rows.push_back('{mk(CMD_DRAW, 1, 1, 5, 3, 3, 5, 5, 5, 5, 9), 1'b1, none});
    rows.push_back('{mk(CMD_DRAW, -2048, -2048, -1, -1, 2047, 0, -2048, 2047, 7, 255),
                     1'b1, none});
    rows.push_back('{mk(CMD_DRAW, 2047, 2047, 3, 2047, -2048, 3, 640, 0, 3, 1), 1'b1, none});
    rows.push_back('{mk(CMD_DRAW, 0, 0, 100, 4, 0, 100, 0, 4, 100, 255), 1'b0, none});
    rows.push_back('{mk(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_DRAW, 0, 0, 32'sh8000_0000, 4, 0, 32'sh8000_0000, 0, 4,
                        32'sh8000_0000, 128), 1'b0, none});
    rows.push_back('{mk(CMD_READ, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_DRAW, 10, 10, 32'sh8000_0000, 10, 14, INT_MAX, 14, 10, 0, 77),
                     1'b0, none});
    rows.push_back('{mk(CMD_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_DRAW, 637, 477, -5, 643, 477, 9, 637, 483, 40, 3), 1'b0, none});
    rows.push_back('{mk(CMD_READ, 639, 479, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk(CMD_DRAW, 30, 30, INT_MAX, 34, 30, INT_MAX, 30, 34, INT_MAX, 5),
                     1'b1, none});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{mk(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fresh});
    rows.push_back('{mk(CMD_DRAW, 2, 2, 0, 2, 2, 0, 2, 2, 0, 6), 1'b1, none});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_cmd(rows[i].cmd);
      log_expect(rows[i].cmd, rows[i].known, rows[i].res);
    end

    // Random part in three idling phases; the sender waits for the block to
    // run dry before each change.
    for (int i = 0; i < 120; i++) begin
      raster_cmd_t c;
      if (i == 40 || i == 80) begin
        item_ch.valid <= 1'b0;
        drain();
        send_idle = (i == 40) ? 68 : 0;
        recv_idle = (i == 40) ? 37 : 0;
      end
      c = rand_cmd();
      send_cmd(c);
      log_expect(c, 1'b0, none);
    end
    item_ch.valid <= 1'b0;

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d draws (%0d pixels written), %0d reads, %0d clears, %0d unused codes.",
             n_draw, n_pixels, n_read, n_clear, n_other);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
